### rtl/sbck_pkg.sv
// Shared types, constants and helper functions of the color-keyed sprite blitter.
// No dependencies; every other file of the block imports this package.
package sbck_pkg;

	localparam int COORD_BITS = 12;
	localparam int POS_BITS   = COORD_BITS + 1;
	localparam int LIN_BITS   = 2 * COORD_BITS + 2;
	localparam int ADDR_BITS  = 32;
	localparam int COLOR_BITS = 32;
	localparam int CFG_BITS   = 32;
	localparam int IDX_BITS   = 3;
	localparam int BPP_BITS   = 3;

	typedef enum logic [IDX_BITS-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_PIXEL_BYTES   = 3'd2,
		REG_TRANSPARENT   = 3'd3,
		REG_FRAME_BASE    = 3'd4
	} reg_idx_t;

	localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH  = COORD_BITS'(800);
	localparam logic [COORD_BITS-1:0] RST_SCREEN_HEIGHT = COORD_BITS'(600);
	localparam logic [BPP_BITS-1:0]   RST_PIXEL_BYTES   = BPP_BITS'(4);

	typedef struct packed {
		logic                  func;
		logic [COORD_BITS-1:0] sprite_x;
		logic [COORD_BITS-1:0] sprite_y;
		logic [COORD_BITS-1:0] sprite_width;
		logic [COORD_BITS-1:0] sprite_height;
		logic [COLOR_BITS-1:0] pixel_color;
	} pix_item_t;

	typedef struct packed {
		logic                  write_enable;
		logic [ADDR_BITS-1:0]  write_address;
		logic [COLOR_BITS-1:0] write_data;
		logic                  sprite_done;
	} wr_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] screen_width;
		logic [COORD_BITS-1:0] screen_height;
		logic [BPP_BITS-1:0]   pixel_bytes;
		logic [COLOR_BITS-1:0] transparent_color;
		logic [ADDR_BITS-1:0]  frame_base;
	} cfg_t;

	// Byte lane mask for the configured pixel size; 0 acts as 1, 5..7 act as 4.
	function automatic logic [COLOR_BITS-1:0] byte_mask(input logic [BPP_BITS-1:0] bpp);
		logic [COLOR_BITS-1:0] m;
		case (bpp)
			3'd0, 3'd1: m = 32'h0000_00FF;
			3'd2:       m = 32'h0000_FFFF;
			3'd3:       m = 32'h00FF_FFFF;
			default:    m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

### rtl/sbck_pix_if.sv
// Pixel input channel of the sprite blitter: valid/ready handshake with a pixel payload.
// Depends on sbck_pkg for the payload type.
interface sbck_pix_if;
	import sbck_pkg::*;

	logic      valid;
	logic      ready;
	pix_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/sbck_wr_if.sv
// Frame buffer write channel of the sprite blitter: valid/ready handshake with a write payload.
// Depends on sbck_pkg for the payload type.
interface sbck_wr_if;
	import sbck_pkg::*;

	logic     valid;
	logic     ready;
	wr_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/sbck_pixel_calc.sv
// Per-pixel logic of the sprite blitter: clipping, color key test and write address.
// Depends on sbck_pkg; combinational, placed between the input and result registers.
module sbck_pixel_calc (
	input  sbck_pkg::pix_item_t                 item,
	input  logic [sbck_pkg::COORD_BITS-1:0]     col,
	input  logic [sbck_pkg::COORD_BITS-1:0]     row,
	input  logic                                done,
	input  sbck_pkg::cfg_t                      cfg,
	output sbck_pkg::wr_item_t                  result
);
	import sbck_pkg::*;

	logic [POS_BITS-1:0]   px;
	logic [POS_BITS-1:0]   py;
	logic                  on_screen;
	logic                  opaque;
	logic                  we;
	logic [COLOR_BITS-1:0] mask;
	logic [LIN_BITS-1:0]   lin;
	logic [LIN_BITS+1:0]   scaled;
	logic [ADDR_BITS-1:0]  addr;

	always_comb begin
		px = {1'b0, item.sprite_x} + {1'b0, col};
		py = {1'b0, item.sprite_y} + {1'b0, row};
		on_screen = (px < {1'b0, cfg.screen_width}) && (py < {1'b0, cfg.screen_height});
		mask = byte_mask(cfg.pixel_bytes);
		opaque = ((item.pixel_color ^ cfg.transparent_color) & mask) != '0;
		we = on_screen && opaque;

		lin = LIN_BITS'(py) * LIN_BITS'(cfg.screen_width) + LIN_BITS'(px);
		// Scale by bytes per pixel with shifts; codes 0 and 5 to 7 fold into the 1 and 4 byte cases.
		case (cfg.pixel_bytes)
			3'd0, 3'd1: scaled = {2'b00, lin};
			3'd2:       scaled = {1'b0, lin, 1'b0};
			3'd3:       scaled = {2'b00, lin} + {1'b0, lin, 1'b0};
			default:    scaled = {lin, 2'b00};
		endcase
		addr = cfg.frame_base + ADDR_BITS'(scaled);

		result.write_enable  = we;
		result.write_address = we ? addr : '0;
		result.write_data    = (we && !item.func) ? (item.pixel_color & mask) : '0;
		result.sprite_done   = done;
	end
endmodule

### rtl/sprite_blit_color_key.sv
// Color-keyed sprite blitter, top level. Depends on sbck_pkg, sbck_pix_if, sbck_wr_if
// and sbck_pixel_calc.
// A pixel passes the input register and then the result register before its write is
// offered. Throughput: one pixel per cycle while the write channel is ready, set by the
// input register and the result register.
// Reset clears the pipeline valid flags and the column and row counters, and loads the
// registers with 800 x 600, 4 bytes per pixel, key 0 and frame base 0.
module sprite_blit_color_key (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sbck_pkg::IDX_BITS-1:0]     cfg_index,
	input  logic [sbck_pkg::CFG_BITS-1:0]     cfg_data,
	sbck_pix_if.sink                          pixels,
	sbck_wr_if.source                         writes
);
	import sbck_pkg::*;

	cfg_t                  cfg_q;
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;

	logic                  valid_s1;
	pix_item_t             item_s1;
	logic [COORD_BITS-1:0] col_s1;
	logic [COORD_BITS-1:0] row_s1;
	logic                  done_s1;

	logic                  valid_s2;
	wr_item_t              result_s2;
	wr_item_t              result_c;

	logic                  advance_s1;
	logic                  accept;
	logic                  row_end;
	logic                  last_row;
	logic                  done_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width      <= RST_SCREEN_WIDTH;
			cfg_q.screen_height     <= RST_SCREEN_HEIGHT;
			cfg_q.pixel_bytes       <= RST_PIXEL_BYTES;
			cfg_q.transparent_color <= '0;
			cfg_q.frame_base        <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  cfg_q.screen_width      <= cfg_data[COORD_BITS-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height     <= cfg_data[COORD_BITS-1:0];
				REG_PIXEL_BYTES:   cfg_q.pixel_bytes       <= cfg_data[BPP_BITS-1:0];
				REG_TRANSPARENT:   cfg_q.transparent_color <= cfg_data[COLOR_BITS-1:0];
				REG_FRAME_BASE:    cfg_q.frame_base        <= cfg_data[ADDR_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign advance_s1   = !valid_s2 || writes.ready;
	assign pixels.ready = !valid_s1 || advance_s1;
	assign accept       = pixels.valid && pixels.ready;

	// A width or height of zero ends the row or sprite at once, same as a size of one.
	always_comb begin
		row_end  = ({1'b0, col_q} + POS_BITS'(1)) >= {1'b0, pixels.data.sprite_width};
		last_row = ({1'b0, row_q} + POS_BITS'(1)) >= {1'b0, pixels.data.sprite_height};
		done_in  = row_end && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (done_in) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + COORD_BITS'(1);
			end else begin
				col_q <= col_q + COORD_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pixels.ready) begin
				valid_s1 <= pixels.valid;
			end
			if (advance_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= pixels.data;
			col_s1  <= col_q;
			row_s1  <= row_q;
			done_s1 <= done_in;
		end
		if (advance_s1 && valid_s1) begin
			result_s2 <= result_c;
		end
	end

	sbck_pixel_calc u_calc (
		.item   (item_s1),
		.col    (col_s1),
		.row    (row_s1),
		.done   (done_s1),
		.cfg    (cfg_q),
		.result (result_c)
	);

	assign writes.valid = valid_s2;
	assign writes.data  = result_s2;

	// A disabled write carries a zero address and zero data.
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		writes.valid && !writes.data.write_enable |->
			writes.data.write_address == '0 && writes.data.write_data == '0)
		else $error("disabled write with nonzero address or data");

	// The last pixel of a sprite returns both counters to the origin.
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && done_in |=> col_q == '0 && row_q == '0)
		else $error("counters not cleared after last pixel");

	// The counters move only on a pixel transfer.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(col_q) && $stable(row_q))
		else $error("counters changed without a transfer");

	// A pending item in the first stage is not lost while the output stalls.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !writes.ready |=> valid_s1 && valid_s2)
		else $error("pipeline item dropped during stall");
endmodule
